@@ rtl/rdd_pkg.sv @@
`timescale 1ns / 1ps

package rdd_pkg;

    localparam int unsigned OFFSET_W = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_TRUNC  = 2'd1,
        ST_BADOFF = 2'd2,
        ST_TRAIL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_HEADER     = 3'd0,
        PH_BODY       = 3'd1,
        PH_EMPTY      = 3'd2,
        PH_PADDED     = 3'd3,
        PH_TERMINATED = 3'd4,
        PH_ENDED      = 3'd5
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEXT_SIZE     = 2'd0,
        CFG_DATA_SIZE     = 2'd1,
        CFG_EOF_ENDS      = 2'd2,
        CFG_ZERO_PAD_OK   = 2'd3
    } t_cfg_index;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_EOF  = 1'b1
    } t_kind;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] stream_byte;
    } t_in_word;

    typedef struct packed {
        logic                result_kind;
        logic                in_data_section;
        logic [OFFSET_W-1:0] section_offset;
        logic [OFFSET_W-1:0] abs_offset;
        t_status             status;
    } t_out_word;

    // word passed from the byte parser to the classifier
    typedef struct packed {
        logic                is_status;
        t_status             status;
        logic [OFFSET_W-1:0] offset;
    } t_s1_word;

endpackage

@@ rtl/rdd_front.sv @@
`timescale 1ns / 1ps

module rdd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rdd_pkg::t_in_word i_in_word,
    input  logic              i_eof_ends_stream,
    input  logic              i_zero_padding_allowed,
    input  logic              i_s1_take,
    output logic              o_s1_valid,
    output rdd_pkg::t_s1_word o_s1_word
);
    import rdd_pkg::*;

    t_phase              r_phase, n_phase;
    logic [1:0]          r_hdr_cnt, n_hdr_cnt;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    t_status             r_first_err, n_first_err;
    logic                r_trailing, n_trailing;
    logic                r_s1_valid, n_s1_valid;
    t_s1_word            r_s1_word, n_s1_word;

    logic                accept;
    logic                push;
    logic [BYTE_W-1:0]   b;
    logic [OFFSET_W-1:0] hdr_offset;
    logic [OFFSET_W-1:0] sum_offset;
    t_status             end_status;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_s1_valid || i_s1_take;
    assign b          = i_in_word.stream_byte;
    assign hdr_offset = {r_offset[OFFSET_W-BYTE_W-1:0], b};
    assign sum_offset = r_offset + ((b == BYTE_W'(1)) ? OFFSET_W'(254)
                                                      : {{(OFFSET_W-BYTE_W){1'b0}}, b});

    always_comb begin
        if (r_first_err != ST_OK) begin
            end_status = r_first_err;
        end else begin
            unique case (r_phase)
                PH_HEADER:     end_status = ST_TRUNC;
                PH_BODY:       end_status = i_eof_ends_stream ? ST_OK : ST_TRUNC;
                PH_EMPTY:      end_status = ST_OK;
                PH_PADDED:     end_status = (r_trailing || !i_zero_padding_allowed)
                                            ? ST_TRAIL : ST_OK;
                PH_TERMINATED: end_status = r_trailing ? ST_TRAIL : ST_OK;
                default:       end_status = ST_OK;
            endcase
        end
    end

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_offset    = r_offset;
        n_first_err = r_first_err;
        n_trailing  = r_trailing;
        if (accept) begin
            if (i_in_word.kind == KIND_EOF) begin
                n_first_err = end_status;
                n_phase     = PH_ENDED;
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        n_offset  = hdr_offset;
                        n_hdr_cnt = r_hdr_cnt + 2'd1;
                        if (r_hdr_cnt == 2'd3) begin
                            n_phase = (hdr_offset == '0) ? PH_EMPTY : PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        if (b == '0) begin
                            n_phase = PH_TERMINATED;
                        end else begin
                            n_offset = sum_offset;
                        end
                    end
                    PH_EMPTY, PH_PADDED: begin
                        n_phase = PH_PADDED;
                        if (b != '0) n_trailing = 1'b1;
                    end
                    PH_TERMINATED: begin
                        if (b != '0) n_trailing = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // outputs toward the classifier
    always_comb begin
        push = 1'b0;
        if (accept) begin
            if (i_in_word.kind == KIND_EOF) begin
                push = 1'b1;
            end else if (r_phase == PH_HEADER) begin
                push = (r_hdr_cnt == 2'd3) && (hdr_offset != '0);
            end else if (r_phase == PH_BODY) begin
                push = (b > BYTE_W'(1));
            end
        end
        n_s1_word.is_status = (i_in_word.kind == KIND_EOF);
        n_s1_word.status    = end_status;
        n_s1_word.offset    = (r_phase == PH_HEADER) ? hdr_offset : sum_offset;
        if (push) begin
            n_s1_valid = 1'b1;
        end else if (i_s1_take) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= '0;
            r_offset    <= '0;
            r_first_err <= ST_OK;
            r_trailing  <= 1'b0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_offset    <= n_offset;
            r_first_err <= n_first_err;
            r_trailing  <= n_trailing;
            r_s1_valid  <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_s1_word <= n_s1_word;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_word  = r_s1_word;

endmodule

@@ rtl/rdd_classify.sv @@
`timescale 1ns / 1ps

module rdd_classify (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [31:0]        i_text_size,
    input  logic [31:0]        i_data_size,
    input  logic               i_s1_valid,
    input  rdd_pkg::t_s1_word  i_s1_word,
    output logic               o_s1_take,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rdd_pkg::t_out_word o_out_word
);
    import rdd_pkg::*;

    logic                r_bad, n_bad;
    logic                r_out_valid, n_out_valid;
    t_out_word           r_out_word, n_out_word;

    logic [OFFSET_W+1:0] total;
    logic [OFFSET_W+1:0] off_end;
    logic                in_text;
    logic                bad;
    logic                emit;

    assign o_s1_take = i_s1_valid && (!r_out_valid || i_out_ready);

    // exact-width checks, no wrap
    assign total   = {2'b00, i_text_size} + {2'b00, i_data_size};
    assign off_end = {2'b00, i_s1_word.offset} + (OFFSET_W+2)'(4);
    assign in_text = i_s1_word.offset < i_text_size;
    assign bad     = in_text ? (off_end > {2'b00, i_text_size}) : (off_end > total);
    assign emit    = i_s1_word.is_status || !(r_bad || bad);

    always_comb begin
        n_bad = r_bad;
        if (o_s1_take && !i_s1_word.is_status && bad) begin
            n_bad = 1'b1;
        end
        if (o_s1_take) begin
            n_out_valid = emit;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
        if (i_s1_word.is_status) begin
            n_out_word.result_kind     = KIND_EOF;
            n_out_word.in_data_section = 1'b0;
            n_out_word.section_offset  = '0;
            n_out_word.abs_offset      = '0;
            n_out_word.status          = r_bad ? ST_BADOFF : i_s1_word.status;
        end else begin
            n_out_word.result_kind     = KIND_BYTE;
            n_out_word.in_data_section = !in_text;
            n_out_word.section_offset  = in_text ? i_s1_word.offset
                                                 : i_s1_word.offset - i_text_size;
            n_out_word.abs_offset      = i_s1_word.offset;
            n_out_word.status          = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_bad       <= n_bad;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_take) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ rtl/relocation_delta_decoder_unit.sv @@
`timescale 1ns / 1ps

// Delta-coded relocation table decoder.
// Input channel (i_in_valid / o_in_ready / i_in_word): one table byte per word,
// then an end-of-input word. Output channel (o_out_valid / i_out_ready /
// o_out_word): relocation entries (text or data, section and image offset),
// and one status word for each end-of-input word.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 text size,
// 1 data size, 2 eof-ends-stream flag, 3 zero-padding-allowed flag. Write only
// while no word is in flight.
// Throughput: one input word per cycle unless the output stalls. The byte parser
// builds each offset from the header or with one 32-bit add per body byte and
// loads a holding register with each result; the classifier then does the
// section bound compares and loads the output register. A word that produces
// a result passes the holding register, then the output register.
// When the receiver stalls, the output register holds its word and the
// holding register still takes one more result-producing word; after that
// o_in_ready drops until the output drains.
// Reset: parser back to the start-offset header, error flags cleared, sizes 0,
// eof flag 0, padding flag 1, both channels empty.
module relocation_delta_decoder_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  rdd_pkg::t_in_word      i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output rdd_pkg::t_out_word     o_out_word,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  rdd_pkg::t_cfg_index    i_cfg_index,
    input  logic [31:0]            i_cfg_data
);
    import rdd_pkg::*;

    logic [OFFSET_W-1:0] r_text_size;
    logic [OFFSET_W-1:0] r_data_size;
    logic                r_eof_ends_stream;
    logic                r_zero_padding_allowed;

    logic                s1_valid;
    logic                s1_take;
    t_s1_word            s1_word;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_size            <= '0;
            r_data_size            <= '0;
            r_eof_ends_stream      <= 1'b0;
            r_zero_padding_allowed <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TEXT_SIZE:   r_text_size            <= i_cfg_data;
                CFG_DATA_SIZE:   r_data_size            <= i_cfg_data;
                CFG_EOF_ENDS:    r_eof_ends_stream      <= i_cfg_data[0];
                CFG_ZERO_PAD_OK: r_zero_padding_allowed <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    rdd_front u_front (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_in_word              (i_in_word),
        .i_eof_ends_stream      (r_eof_ends_stream),
        .i_zero_padding_allowed (r_zero_padding_allowed),
        .i_s1_take              (s1_take),
        .o_s1_valid             (s1_valid),
        .o_s1_word              (s1_word)
    );

    rdd_classify u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text_size (r_text_size),
        .i_data_size (r_data_size),
        .i_s1_valid  (s1_valid),
        .i_s1_word   (s1_word),
        .o_s1_take   (s1_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_entry_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.result_kind == KIND_BYTE)
        |-> (o_out_word.status == ST_OK
             && o_out_word.section_offset <= o_out_word.abs_offset))
        else $error("relocation entry with bad status or offsets");

    a_status_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.result_kind == KIND_EOF)
        |-> (o_out_word.section_offset == '0 && o_out_word.abs_offset == '0
             && !o_out_word.in_data_section))
        else $error("status word carries offset fields");

endmodule
